@@ hw/rtl/v3mu_pkg.sv @@
// Shared types and opcodes for the three-component vector unit.
package v3mu_pkg;

    typedef enum logic [3:0] {
        OP_LOAD      = 4'd0,
        OP_CLEAR     = 4'd1,
        OP_INVERT    = 4'd2,
        OP_ADD       = 4'd3,
        OP_SUB       = 4'd4,
        OP_SCALE     = 4'd5,
        OP_ADDSCALED = 4'd6,
        OP_COMPMUL   = 4'd7,
        OP_CROSS     = 4'd8,
        OP_DOT       = 4'd9,
        OP_SQMAG     = 4'd10,
        OP_MAG       = 4'd11,
        OP_NORM      = 4'd12
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_DIV,
        ST_DONE,
        ST_OUT
    } t_state;

endpackage

@@ hw/rtl/vector3_math_unit_core.sv @@
// Accumulator vector unit with a shared multiplier, square root and divider.
// load/clear/invert/add/sub skip the multiplier; other ops take a product per component,
// cross two; mag adds a square root; normalise also divides components of a nonzero vector.
// One item at a time: the next item is taken in the cycle after the result loads.
// The result waits in an output register until taken; the next result waits for that.
// Reset (synchronous, active low) clears the accumulator and the sequencer.
module vector3_math_unit_core
    import v3mu_pkg::*;
#(
    parameter int COMP_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // op[3:0], write_back[4], in_x, in_y, in_z, in_scalar
    input  logic [4*COMP_WIDTH+7:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // out_x, out_y, out_z, out_scalar, saturated
    output logic [4*COMP_WIDTH+7:0] m_axis_tdata
);
    localparam int W  = COMP_WIDTH;
    localparam int PW = 2 * W + 4;
    localparam int RW = W + 2;
    localparam int CW = $clog2(PW + 1);
    localparam logic signed [PW-1:0] CMAXW = PW'((64'sd1 <<< (W - 1)) - 1);
    localparam logic signed [PW-1:0] CMINW = -CMAXW - PW'(1);

    t_state r_state, n_state;
    t_op    r_op;
    logic   r_wb, r_sat, r_valid;
    logic signed [W-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz, r_s;
    logic signed [W-1:0] r_rx, r_ry, r_rz, r_sc;
    logic signed [PW-1:0] r_p0, r_p1, r_p2;
    logic [1:0]  r_k;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_rem, r_rad;
    logic [PW-1:0] r_root;
    logic [W:0]    r_q;
    logic [4*W+7:0] r_tdata;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_valid;

    // shared signed multiplier operands
    logic signed [W-1:0] m_a, m_b;
    logic signed [2*W-1:0] m_p;
    always_comb begin
        m_a = r_ax;
        m_b = r_s;
        case (r_op)
            OP_SCALE: begin
                m_a = (r_k == 2'd0) ? r_ax : (r_k == 2'd1) ? r_ay : r_az;
                m_b = r_s;
            end
            OP_ADDSCALED: begin
                m_a = (r_k == 2'd0) ? r_bx : (r_k == 2'd1) ? r_by : r_bz;
                m_b = r_s;
            end
            OP_COMPMUL, OP_DOT: begin
                m_a = (r_k == 2'd0) ? r_ax : (r_k == 2'd1) ? r_ay : r_az;
                m_b = (r_k == 2'd0) ? r_bx : (r_k == 2'd1) ? r_by : r_bz;
            end
            OP_CROSS: begin
                if (!r_cnt[0]) begin
                    m_a = (r_k == 2'd0) ? r_ay : (r_k == 2'd1) ? r_az : r_ax;
                    m_b = (r_k == 2'd0) ? r_bz : (r_k == 2'd1) ? r_bx : r_by;
                end else begin
                    m_a = (r_k == 2'd0) ? r_az : (r_k == 2'd1) ? r_ax : r_ay;
                    m_b = (r_k == 2'd0) ? r_by : (r_k == 2'd1) ? r_bz : r_bx;
                end
            end
            default: begin
                m_a = (r_k == 2'd0) ? r_ax : (r_k == 2'd1) ? r_ay : r_az;
                m_b = m_a;
            end
        endcase
    end
    assign m_p = m_a * m_b;

    logic signed [PW-1:0] m_val;
    assign m_val = (r_op == OP_CROSS && r_cnt[0]) ? -PW'(m_p) : PW'(m_p);

    function automatic logic signed [W-1:0] sat_w(input logic signed [PW-1:0] v,
                                                   output logic f);
        f = 1'b0;
        if (v > CMAXW) begin
            f = 1'b1;
            return CMAXW[W-1:0];
        end
        if (v < CMINW) begin
            f = 1'b1;
            return CMINW[W-1:0];
        end
        return v[W-1:0];
    endfunction

    logic [PW-1:0] sq_t, sq_rem_n;
    logic [PW-1:0] sq_root_n;
    always_comb begin
        sq_t = r_root + r_rad;
        sq_rem_n = r_rem;
        sq_root_n = r_root >> 1;
        if (r_rem >= sq_t) begin
            sq_rem_n = r_rem - sq_t;
            sq_root_n = (r_root >> 1) + r_rad;
        end
    end

    logic [RW:0] dv_r;
    always_comb dv_r = {r_rem[RW-1:0], 1'b0};

    logic [W-1:0] cur_mag;
    logic signed [W-1:0] cur_c;
    always_comb begin
        cur_c = (r_k == 2'd0) ? r_ax : (r_k == 2'd1) ? r_ay : r_az;
        cur_mag = cur_c[W-1] ? W'(-cur_c) : W'(cur_c);
    end

    logic f0, f1, f2;
    logic signed [W-1:0] sv0, sv1, sv2;
    logic signed [PW-1:0] e0, e1, e2, dq;
    always_comb begin
        e0 = PW'(r_ax); e1 = PW'(r_ay); e2 = PW'(r_az);
        case (r_op)
            OP_INVERT: begin
                e0 = -PW'(r_ax); e1 = -PW'(r_ay); e2 = -PW'(r_az);
            end
            OP_ADD: begin
                e0 = PW'(r_ax) + PW'(r_bx); e1 = PW'(r_ay) + PW'(r_by);
                e2 = PW'(r_az) + PW'(r_bz);
            end
            OP_SUB: begin
                e0 = PW'(r_ax) - PW'(r_bx); e1 = PW'(r_ay) - PW'(r_by);
                e2 = PW'(r_az) - PW'(r_bz);
            end
            OP_ADDSCALED: begin
                e0 = PW'(r_ax) + (r_p0 >>> FRAC_BITS);
                e1 = PW'(r_ay) + (r_p1 >>> FRAC_BITS);
                e2 = PW'(r_az) + (r_p2 >>> FRAC_BITS);
            end
            OP_SCALE, OP_COMPMUL, OP_CROSS: begin
                e0 = r_p0 >>> FRAC_BITS; e1 = r_p1 >>> FRAC_BITS;
                e2 = r_p2 >>> FRAC_BITS;
            end
            OP_DOT, OP_SQMAG: begin
                e0 = (r_p0 + r_p1 + r_p2) >>> FRAC_BITS;
            end
            default: ;
        endcase
        sv0 = sat_w(e0, f0);
        sv1 = sat_w(e1, f1);
        sv2 = sat_w(e2, f2);
        dq = cur_c[W-1] ? -PW'(r_q) : PW'(r_q);
    end
    logic fd;
    logic signed [W-1:0] svd;
    always_comb svd = sat_w(dq, fd);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_MUL;
            ST_MUL: begin
                if (r_op == OP_SCALE || r_op == OP_ADDSCALED || r_op == OP_COMPMUL
                        || r_op == OP_CROSS || r_op == OP_DOT || r_op == OP_SQMAG
                        || r_op == OP_MAG || r_op == OP_NORM) begin
                    if (r_k == 2'd2 && (r_op != OP_CROSS || r_cnt[0])) begin
                        n_state = (r_op == OP_MAG || r_op == OP_NORM) ? ST_SQRT : ST_DONE;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SQRT: if (r_rad == '0) n_state = (r_op == OP_NORM) ? ST_DIV : ST_DONE;
            ST_DIV: if (r_root == '0 || (r_k == 2'd2 && r_cnt == '0)) n_state = ST_DONE;
            ST_DONE: n_state = ST_OUT;
            ST_OUT: if (!r_valid || m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_ax <= '0; r_ay <= '0; r_az <= '0;
        end else begin
            r_state <= n_state;
            if (r_valid && m_axis_tready && r_state != ST_OUT) r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: if (s_axis_tvalid) begin
                    r_op  <= t_op'(s_axis_tdata[3:0]);
                    r_wb  <= s_axis_tdata[4];
                    r_bx  <= s_axis_tdata[5+:W];
                    r_by  <= s_axis_tdata[5+W+:W];
                    r_bz  <= s_axis_tdata[5+2*W+:W];
                    r_s   <= s_axis_tdata[5+3*W+:W];
                    r_k   <= 2'd0;
                    r_cnt <= '0;
                    r_p0 <= '0; r_p1 <= '0; r_p2 <= '0;
                    r_sat <= 1'b0;
                end
                ST_MUL: begin
                    case (r_k)
                        2'd0: r_p0 <= (r_op == OP_CROSS && r_cnt[0]) ? r_p0 + m_val : m_val;
                        2'd1: r_p1 <= (r_op == OP_CROSS && r_cnt[0]) ? r_p1 + m_val : m_val;
                        default: r_p2 <= (r_op == OP_CROSS && r_cnt[0]) ? r_p2 + m_val : m_val;
                    endcase
                    if (r_op == OP_CROSS && !r_cnt[0]) begin
                        r_cnt <= CW'(1);
                    end else begin
                        r_cnt <= '0;
                        r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                    end
                    r_rem  <= PW'(r_p0 + r_p1 + m_val);
                    r_root <= '0;
                    r_rad  <= PW'(1) << (2 * RW - 2);
                end
                ST_SQRT: begin
                    if (r_rad != '0) begin
                        r_rem  <= sq_rem_n;
                        r_root <= sq_root_n;
                        r_rad  <= r_rad >> 2;
                    end
                    r_k    <= 2'd0;
                    r_cnt  <= CW'(FRAC_BITS + 1);
                    r_q    <= '0;
                end
                ST_DIV: begin
                    if (r_cnt == CW'(FRAC_BITS + 1)) begin
                        r_q   <= (W + 1)'(cur_mag >= W'(r_root));
                        r_rem <= PW'(cur_mag >= W'(r_root) ? cur_mag - W'(r_root) : cur_mag);
                        r_cnt <= r_cnt - CW'(1);
                    end else if (r_cnt != '0) begin
                        if (dv_r >= (RW + 1)'(r_root)) begin
                            r_rem <= PW'(dv_r - (RW + 1)'(r_root));
                            r_q   <= {r_q[W-1:0], 1'b1};
                        end else begin
                            r_rem <= PW'(dv_r);
                            r_q   <= {r_q[W-1:0], 1'b0};
                        end
                        r_cnt <= r_cnt - CW'(1);
                    end else begin
                        case (r_k)
                            2'd0: r_rx <= svd;
                            2'd1: r_ry <= svd;
                            default: r_rz <= svd;
                        endcase
                        r_sat <= r_sat | fd;
                        r_k   <= r_k + 2'd1;
                        r_cnt <= CW'(FRAC_BITS + 1);
                        r_q   <= '0;
                    end
                end
                ST_DONE: begin
                    r_sc <= '0;
                    case (r_op)
                        OP_LOAD: begin
                            r_rx <= r_bx; r_ry <= r_by; r_rz <= r_bz;
                        end
                        OP_CLEAR: begin
                            r_rx <= '0; r_ry <= '0; r_rz <= '0;
                        end
                        OP_INVERT, OP_ADD, OP_SUB, OP_SCALE, OP_ADDSCALED,
                        OP_COMPMUL, OP_CROSS: begin
                            r_rx <= sv0; r_ry <= sv1; r_rz <= sv2;
                            r_sat <= f0 | f1 | f2;
                        end
                        OP_DOT, OP_SQMAG: begin
                            r_rx <= r_ax; r_ry <= r_ay; r_rz <= r_az;
                            r_sc <= sv0; r_sat <= f0;
                        end
                        OP_MAG: begin
                            r_rx <= r_ax; r_ry <= r_ay; r_rz <= r_az;
                            if (r_root > PW'(CMAXW)) begin
                                r_sc <= CMAXW[W-1:0]; r_sat <= 1'b1;
                            end else begin
                                r_sc <= W'(r_root);
                            end
                        end
                        OP_NORM: if (r_root == '0) begin
                            r_rx <= r_ax; r_ry <= r_ay; r_rz <= r_az;
                        end
                        default: begin
                            r_rx <= r_ax; r_ry <= r_ay; r_rz <= r_az;
                        end
                    endcase
                end
                ST_OUT: if (!r_valid || m_axis_tready) begin
                    r_valid <= 1'b1;
                    r_tdata <= {7'd0, r_sat, r_sc, r_rz, r_ry, r_rx};
                    if (r_wb && r_op <= OP_CROSS || r_wb && r_op == OP_NORM) begin
                        r_ax <= r_rx; r_ay <= r_ry; r_az <= r_rz;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tdata = r_tdata;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == ST_IDLE)) else $error("ready outside idle");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
`endif

endmodule
